// ===== rtl/core/srx_pkg.sv =====
// ----------------------------------------------------------------------------
// srx_pkg
// Shared types and constants for the serial frame receiver.
// ----------------------------------------------------------------------------
package srx_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam logic [7:0] NEW_CLIENT_TAG = 8'h01;
    localparam logic [7:0] SHORT_LEN      = 8'h16;
    localparam logic [7:0] LONG_LEN       = 8'h2F;
    localparam int         SHORT_BODY     = 21;
    localparam int         LONG_BODY      = 46;
    localparam int         BODY_START     = 7;
    localparam int         HEADER_LEN     = 6;
    localparam int         NEWC_COUNT     = 4;

    typedef enum logic [1:0] {
        KIND_NEW_CLIENT = 2'd0,
        KIND_SHORT      = 2'd1,
        KIND_LONG       = 2'd2
    } srx_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NEWC,
        ST_FETCH,
        ST_SEND
    } srx_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // store the incoming byte
        logic rd_en;    // load the next payload byte from the frame buffer
        logic advance;  // step the payload index after a delivered beat
    } srx_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic newc;     // accepting now would complete a new-client header
        logic burst;    // accepting now would complete a frame with payload
        logic last;     // the payload beat on display is the final one
    } srx_status_t;

endpackage

// ===== rtl/core/srx_dpath.sv =====
// ----------------------------------------------------------------------------
// srx_dpath
// Frame buffer, byte counter, header capture and payload readout.
// ----------------------------------------------------------------------------
module srx_dpath #(
    parameter int BUFFER_DEPTH = srx_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  srx_pkg::srx_cmd_t   cmd,
    input  logic [7:0]          rx_byte,
    output srx_pkg::srx_status_t status,
    output logic [1:0]          kind,
    output logic [7:0]          payload_byte,
    output logic [5:0]          byte_index,
    output logic [7:0]          peer_high,
    output logic [7:0]          peer_low
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = AW + 1;
    localparam int EW = CW + 8;

    logic [7:0]    mem [BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] count_reg, count_next;
    logic [CW-1:0] cnt_inc;
    logic [EW-1:0] body_cnt;
    logic [7:0]    hdr0_reg, hdr1_reg, hdr2_reg, hdr4_reg;
    srx_pkg::srx_kind_t kind_reg;
    logic [5:0]    idx_reg;
    logic [AW-1:0] rd_addr;
    logic          is_short, is_long, frame_end;

    assign cnt_inc   = {1'b0, count_reg} + CW'(1);
    assign body_cnt  = EW'(cnt_inc) - EW'(srx_pkg::HEADER_LEN);
    assign is_short  = (hdr4_reg == srx_pkg::SHORT_LEN);
    assign is_long   = (hdr4_reg == srx_pkg::LONG_LEN);
    assign frame_end = (cnt_inc >= CW'(srx_pkg::HEADER_LEN)) && (body_cnt == EW'(hdr4_reg));

    assign status.newc  = (cnt_inc == CW'(srx_pkg::NEWC_COUNT))
                          && (hdr0_reg == srx_pkg::NEW_CLIENT_TAG);
    assign status.burst = frame_end && (is_short || is_long);
    assign status.last  = (kind_reg == srx_pkg::KIND_SHORT)
                          ? (idx_reg == 6'(srx_pkg::SHORT_BODY - 1))
                          : (idx_reg == 6'(srx_pkg::LONG_BODY - 1));

    always_comb begin
        if (status.newc || frame_end) begin
            count_next = '0;
        end else if (cnt_inc >= CW'(BUFFER_DEPTH)) begin
            count_next = '0;
        end else begin
            count_next = cnt_inc[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.accept) begin
            count_reg <= count_next;
        end
    end

    // Frame buffer write and registered read.
    assign rd_addr = AW'(srx_pkg::BODY_START) + AW'(idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mem[count_reg] <= rx_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Header bytes are kept in registers as well, since they are needed
    // at the same time as payload reads.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (count_reg == AW'(0)) hdr0_reg <= rx_byte;
            if (count_reg == AW'(1)) hdr1_reg <= rx_byte;
            if (count_reg == AW'(2)) hdr2_reg <= rx_byte;
            if (count_reg == AW'(4)) hdr4_reg <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg  <= '0;
            kind_reg <= status.newc ? srx_pkg::KIND_NEW_CLIENT
                      : (is_short ? srx_pkg::KIND_SHORT : srx_pkg::KIND_LONG);
        end else if (cmd.advance) begin
            idx_reg <= idx_reg + 6'd1;
        end
    end

    assign kind         = kind_reg;
    assign payload_byte = (kind_reg == srx_pkg::KIND_NEW_CLIENT) ? 8'h00 : rd_data_reg;
    assign byte_index   = idx_reg;
    assign peer_high    = hdr1_reg;
    assign peer_low     = hdr2_reg;

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, count_reg} < CW'(BUFFER_DEPTH)))
        else $error("byte count beyond buffer depth");

    a_idx_in_body: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (idx_reg < 6'(srx_pkg::LONG_BODY)))
        else $error("payload index beyond packet body");

    a_read_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (kind_reg != srx_pkg::KIND_NEW_CLIENT))
        else $error("payload read during a new-client event");

endmodule

// ===== rtl/core/srx_ctrl.sv =====
// ----------------------------------------------------------------------------
// srx_ctrl
// Sequencer for byte intake and payload bursts.
// ----------------------------------------------------------------------------
module srx_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  srx_pkg::srx_status_t status,
    output srx_pkg::srx_cmd_t    cmd
);

    srx_pkg::srx_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srx_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srx_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (status.newc) begin
                        state_next = srx_pkg::ST_NEWC;
                    end else if (status.burst) begin
                        state_next = srx_pkg::ST_FETCH;
                    end
                end
            end
            srx_pkg::ST_NEWC: begin
                if (out_ready) state_next = srx_pkg::ST_IDLE;
            end
            srx_pkg::ST_FETCH: begin
                state_next = srx_pkg::ST_SEND;
            end
            srx_pkg::ST_SEND: begin
                if (out_ready) begin
                    state_next = status.last ? srx_pkg::ST_IDLE : srx_pkg::ST_FETCH;
                end
            end
            default: state_next = srx_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            srx_pkg::ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            srx_pkg::ST_NEWC: begin
                out_valid = 1'b1;
            end
            srx_pkg::ST_FETCH: begin
                cmd.rd_en = 1'b1;
            end
            srx_pkg::ST_SEND: begin
                out_valid   = 1'b1;
                cmd.advance = out_ready && !status.last;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("input and output active together");

    a_newc_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.newc) |=> (state_reg == srx_pkg::ST_NEWC))
        else $error("new-client event not presented after header");

    a_fetch_then_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srx_pkg::ST_FETCH) |=> out_valid)
        else $error("payload fetch not followed by a beat");

endmodule

// ===== rtl/core/serial_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit
// Collects serial bytes into frames and emits new-client events and payloads.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  -------  ---------  ------------------------------------------------------
//  s_       in         s_tdata[7:0] = rx_byte
//  m_       out        m_tuser[1:0] = kind; m_tdata = payload_byte, byte_index,
//                      peer_high, peer_low (low bit first, zero padded);
//                      m_tlast = last beat of burst
//
//  Input beats are accepted whenever no result is pending.
//  A new-client event is one output beat; each beat of a payload burst is a
//  buffer read (FETCH) followed by its presentation (SEND), as the frame
//  buffer has a single read port; short packets carry 21 beats, long ones 46.
//  The input is held off (s_tready low) while any result is pending, and
//  output stalls simply hold the current beat.
//  Reset (aresetn low, synchronous) clears the byte count and the sequencer;
//  the frame buffer is not cleared, as every read follows a write in the
//  same frame.
//
// ----------------------------------------------------------------------------
module serial_frame_receiver_unit #(
    parameter int BUFFER_DEPTH = srx_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [13:8] byte_index,
                                   // [21:14] peer_high, [29:22] peer_low,
                                   // [31:30] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    srx_pkg::srx_cmd_t    cmd;
    srx_pkg::srx_status_t status;
    logic [1:0]           kind;
    logic [7:0]           payload_byte;
    logic [5:0]           byte_index;
    logic [7:0]           peer_high;
    logic [7:0]           peer_low;

    // The sequencer decides when bytes are taken and when beats go out.
    srx_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the frame and produces the beat fields.
    srx_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .rx_byte      (s_tdata),
        .status       (status),
        .kind         (kind),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .peer_high    (peer_high),
        .peer_low     (peer_low)
    );

    assign m_tdata = {2'b00, peer_low, peer_high, byte_index, payload_byte};
    assign m_tuser = kind;

    // A new-client event is a burst of one beat.
    assign m_tlast = (kind == srx_pkg::KIND_NEW_CLIENT) || status.last;

endmodule
